@@ rtl/iu_pkg.sv @@
// Shared types and constants for the integer pixel upscaler.
package iu_pkg;

   // Default line buffer depth in pixels
   localparam int MAX_WIDTH_DEF = 1024;

   // Field and register widths
   localparam int PIXEL_W     = 24;
   localparam int SCALE_W     = 7;
   localparam int ROW_WIDTH_W = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   // Largest enlargement factor honored
   localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;
   localparam logic [SCALE_W-1:0] SCALE_MIN = 7'd1;

   // Value carried by a padding byte
   localparam logic [PIXEL_W-1:0] PAD_BYTE = 24'h000000;

   // Request action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_PULL  = 1'b1;

   // Result kind codes
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_PAD   = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_WIDTH = 1'd1;

   // Result queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // Classified result handed from front to back
   typedef struct packed {
      logic valid;
      logic kind;
      logic row_end;
      logic group_end;
   } iu_tag_type;

endpackage

@@ rtl/iu_line_mem.sv @@
// Line buffer: one write port, one registered read port.
module iu_line_mem #(
   parameter int MAX_WIDTH = iu_pkg::MAX_WIDTH_DEF,
   parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [iu_pkg::PIXEL_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [iu_pkg::PIXEL_W-1:0] rd_data
);
   import iu_pkg::*;

   logic [PIXEL_W-1:0] mem_ff [MAX_WIDTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/iu_front.sv @@
// Front end: config registers, fill/emit control and result classification.
module iu_front #(
   parameter int MAX_WIDTH = iu_pkg::MAX_WIDTH_DEF,
   parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   // config port
   input  logic                           csr_write,
   input  logic [iu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_action,
   // line buffer access
   output logic                           mem_wr_en,
   output logic [AW-1:0]                  mem_wr_addr,
   output logic                           mem_rd_en,
   output logic [AW-1:0]                  mem_rd_addr,
   // classified result toward the back end
   output iu_pkg::iu_tag_type             tag
);
   import iu_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam logic [CW-1:0] WIDTH_MAX = CW'(MAX_WIDTH);

   // Config registers
   logic [SCALE_W-1:0]     scale_ff;
   logic [ROW_WIDTH_W-1:0] row_width_ff;

   // Control state
   logic [CW-1:0]      fill_count_ff, fill_count_in;
   logic [CW-1:0]      out_column_ff, out_column_in;
   logic [SCALE_W-1:0] copy_index_ff, copy_index_in;
   logic [SCALE_W-1:0] row_index_ff, row_index_in;
   logic [1:0]         pad_index_ff, pad_index_in;
   logic               emitting_ff, emitting_in;

   logic [SCALE_W-1:0] n_eff;
   logic [CW-1:0]      w_eff;
   logic [1:0]         pad_cnt;
   logic [3:0]         pad_prod;
   logic               accept;
   logic               col_done;
   logic               row_last;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_MIN;
         row_width_ff <= ROW_WIDTH_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_SCALE:     scale_ff     <= csr_wdata[SCALE_W-1:0];
            REG_ROW_WIDTH: row_width_ff <= csr_wdata[ROW_WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp registers to their meaningful ranges
   always_comb begin
      if (scale_ff < SCALE_MIN) begin
         n_eff = SCALE_MIN;
      end else if (scale_ff > SCALE_MAX) begin
         n_eff = SCALE_MAX;
      end else begin
         n_eff = scale_ff;
      end
      if (row_width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(row_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = CW'(row_width_ff);
      end
   end

   // Padding bytes per row: (width * scale) mod 4
   assign pad_prod = 2'(w_eff) * n_eff[1:0];
   assign pad_cnt  = pad_prod[1:0];

   assign accept = req_valid & ~req_stall;

   // Next-state and classification
   always_comb begin
      fill_count_in = fill_count_ff;
      out_column_in = out_column_ff;
      copy_index_in = copy_index_ff;
      row_index_in  = row_index_ff;
      pad_index_in  = pad_index_ff;
      emitting_in   = emitting_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      col_done      = 1'b0;
      row_last      = 1'b0;
      tag           = '0;

      if (accept && req_action == ACT_WRITE && !emitting_ff) begin
         // store one pixel; switch to emission once the row is complete
         if (fill_count_ff < w_eff) begin
            mem_wr_en     = 1'b1;
            fill_count_in = fill_count_ff + CW'(1);
         end
         if (fill_count_in >= w_eff) begin
            emitting_in   = 1'b1;
            out_column_in = '0;
            copy_index_in = '0;
            row_index_in  = '0;
            pad_index_in  = '0;
         end
      end else if (accept && req_action == ACT_PULL && emitting_ff) begin
         tag.valid = 1'b1;
         if (out_column_ff < w_eff) begin
            // repeated pixel
            col_done  = ({1'b0, copy_index_ff} + (SCALE_W+1)'(1)) >= {1'b0, n_eff};
            mem_rd_en = 1'b1;
            tag.kind  = KIND_PIXEL;
            row_last  = col_done && pad_cnt == 2'd0 &&
                        (({1'b0, out_column_ff} + (CW+1)'(1)) >= {1'b0, w_eff});
            if (col_done) begin
               copy_index_in = '0;
               out_column_in = out_column_ff + CW'(1);
            end else begin
               copy_index_in = copy_index_ff + SCALE_W'(1);
            end
         end else begin
            // trailing padding byte
            tag.kind     = KIND_PAD;
            row_last     = ({1'b0, pad_index_ff} + 3'd1) >= {1'b0, pad_cnt};
            pad_index_in = pad_index_ff + 2'd1;
         end

         // end of row, and possibly of the row group
         if (row_last) begin
            out_column_in = '0;
            copy_index_in = '0;
            pad_index_in  = '0;
            if (({1'b0, row_index_ff} + (SCALE_W+1)'(1)) >= {1'b0, n_eff}) begin
               tag.group_end = 1'b1;
               row_index_in  = '0;
               emitting_in   = 1'b0;
               fill_count_in = '0;
            end else begin
               row_index_in = row_index_ff + SCALE_W'(1);
            end
         end
         tag.row_end = row_last;
      end
   end

   assign mem_wr_addr = fill_count_ff[AW-1:0];
   assign mem_rd_addr = out_column_ff[AW-1:0];

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         out_column_ff <= '0;
         copy_index_ff <= '0;
         row_index_ff  <= '0;
         pad_index_ff  <= '0;
         emitting_ff   <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         out_column_ff <= out_column_in;
         copy_index_ff <= copy_index_in;
         row_index_ff  <= row_index_in;
         pad_index_ff  <= pad_index_in;
         emitting_ff   <= emitting_in;
      end
   end

endmodule

@@ rtl/iu_back.sv @@
// Back end: joins buffer read data with its tag and queues results.
module iu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  iu_pkg::iu_tag_type         tag,
   input  logic [iu_pkg::PIXEL_W-1:0] mem_rd_data,
   output logic                       full,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic [iu_pkg::PIXEL_W-1:0] rsp_value,
   output logic                       rsp_row_end,
   output logic                       rsp_group_end
);
   import iu_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] value;
      logic               row_end;
      logic               group_end;
   } entry_type;

   iu_tag_type       s1_ff;
   entry_type        queue_ff [QUEUE_DEPTH];
   entry_type        push_entry;
   logic [PW-1:0]    head_ff, tail_ff;
   logic [NW-1:0]    count_ff, count_in;
   logic             push, pop;

   // Tag is registered to line up with the registered buffer read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= tag;
      end
   end

   assign push = s1_ff.valid;
   assign pop  = rsp_valid & ~rsp_stall;

   // Pad bytes carry zero, pixels carry the buffer data
   always_comb begin
      push_entry.kind      = s1_ff.kind;
      push_entry.value     = (s1_ff.kind == KIND_PAD) ? PAD_BYTE : mem_rd_data;
      push_entry.row_end   = s1_ff.row_end;
      push_entry.group_end = s1_ff.group_end;
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= push_entry;
      end
   end

   // Queue pointers and occupancy
   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + NW'(1);
         2'b01:   count_in = count_ff - NW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + PW'(1);
         end
         if (pop) begin
            head_ff <= head_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   // Hold off new transactions when queue plus in-flight slot could overflow
   assign full = (32'(count_ff) + 32'(s1_ff.valid)) >= QUEUE_DEPTH;

   assign rsp_valid     = count_ff != '0;
   assign rsp_kind      = queue_ff[head_ff].kind;
   assign rsp_value     = queue_ff[head_ff].value;
   assign rsp_row_end   = queue_ff[head_ff].row_end;
   assign rsp_group_end = queue_ff[head_ff].group_end;

endmodule

@@ rtl/integer_pixel_upscaler.sv @@
// Nearest-neighbor integer upscaler: fills a line buffer with one input row of
// 24-bit pixels, then on each pull transaction returns the next output item: every
// stored pixel repeated scale times per row, zero padding bytes to a four-byte
// row boundary, scale rows in all, flagged by row_end and group_end. One request
// transaction is taken every clock unless req_stall is high.
// The request side stalls only when the four-entry result queue plus the one
// transaction reading the line buffer would fill it, so a response side that never
// stalls sees one result per clock. The line buffer holds MAX_WIDTH pixels in a
// single-port-write, registered-read memory that needs no clearing after reset.
// Writes during emission and pulls during filling are taken and produce nothing.
module integer_pixel_upscaler #(
   parameter int MAX_WIDTH = iu_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // config port
   input  logic                           csr_write,
   input  logic [iu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [iu_pkg::PIXEL_W-1:0]     req_pixel,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_kind,
   output logic [iu_pkg::PIXEL_W-1:0]     rsp_value,
   output logic                           rsp_row_end,
   output logic                           rsp_group_end
);
   import iu_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [PIXEL_W-1:0] mem_rd_data;
   logic               queue_full;
   iu_tag_type         tag;

   assign req_stall = queue_full;

   iu_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .tag         (tag)
   );

   iu_line_mem #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_pixel),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   iu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .tag           (tag),
      .mem_rd_data   (mem_rd_data),
      .full          (queue_full),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_value     (rsp_value),
      .rsp_row_end   (rsp_row_end),
      .rsp_group_end (rsp_group_end)
   );

endmodule
